@@ rtl/zph_pkg.sv @@
package zph_pkg;

    localparam int NUM_SQUARES = 32;
    localparam int MAP_W       = 32;
    localparam int WORD_W      = 64;
    localparam int INDEX_W     = 8;
    localparam int ORIGIN_W    = 6;

    localparam int LIMIT       = (NUM_SQUARES < MAP_W) ? NUM_SQUARES : MAP_W;
    localparam int PIECE_DEPTH = 4 * NUM_SQUARES;
    localparam int SIDE_INDEX  = 5 * NUM_SQUARES;
    localparam int MEM_DEPTH   = SIDE_INDEX;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int STEP_W      = $clog2(LIMIT + 1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_HASH = 1'b1;

    localparam logic [1:0] PIECE_WHITE_MAN  = 2'd0;
    localparam logic [1:0] PIECE_WHITE_KING = 2'd1;
    localparam logic [1:0] PIECE_BLACK_MAN  = 2'd2;
    localparam logic [1:0] PIECE_BLACK_KING = 2'd3;

    typedef struct packed {
        logic              load;
        logic              start;
        logic              rd_piece;
        logic              rd_chain;
        logic              push;
        logic [STEP_W-1:0] step;
    } t_cmd;

endpackage

@@ rtl/zph_ctrl.sv @@
module zph_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_kind,
    input  logic          i_stall,
    output logic          o_stall,
    output logic          o_valid,
    output zph_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    logic [1:0]                 r_state, n_state;
    logic [zph_pkg::STEP_W-1:0] r_step, n_step;
    logic                       r_out_valid, n_out_valid;
    logic                       accept;
    logic                       slot_free;

    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_out_valid;
    assign accept    = i_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        n_out_valid    = r_out_valid && i_stall;
        o_cmd          = '0;
        o_cmd.step     = r_step;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load  = accept && (i_kind == zph_pkg::KIND_LOAD);
                o_cmd.start = accept && (i_kind == zph_pkg::KIND_HASH);
                if (o_cmd.start) begin
                    n_state = S_RUN;
                    n_step  = '0;
                end
            end
            S_RUN: begin
                if (r_step == zph_pkg::STEP_W'(zph_pkg::LIMIT)) begin
                    o_cmd.rd_chain = 1'b1;
                    n_state        = S_LAST;
                end else begin
                    o_cmd.rd_piece = 1'b1;
                    n_step         = r_step + 1'b1;
                end
            end
            S_LAST: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (slot_free) begin
                    o_cmd.push  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/zph_datapath.sv @@
module zph_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  zph_pkg::t_cmd                 i_cmd,
    input  logic [zph_pkg::INDEX_W-1:0]   i_table_index,
    input  logic [zph_pkg::WORD_W-1:0]    i_table_word,
    input  logic [zph_pkg::MAP_W-1:0]     i_white_pieces,
    input  logic [zph_pkg::MAP_W-1:0]     i_black_pieces,
    input  logic [zph_pkg::MAP_W-1:0]     i_king_marks,
    input  logic                          i_white_to_move,
    input  logic [zph_pkg::ORIGIN_W-1:0]  i_chain_origin_square,
    output logic [zph_pkg::WORD_W-1:0]    o_position_hash
);

    logic [zph_pkg::WORD_W-1:0] mem [zph_pkg::MEM_DEPTH];
    logic [zph_pkg::WORD_W-1:0] r_side_word;
    logic [zph_pkg::WORD_W-1:0] r_rdata;
    logic [zph_pkg::WORD_W-1:0] r_acc, n_acc;
    logic [zph_pkg::WORD_W-1:0] r_out;
    logic [zph_pkg::MAP_W-1:0]  r_white, r_black, r_kings;
    logic [4:0]                 r_origin;
    logic                       r_chain_ok;
    logic                       r_rd_en, n_rd_en;

    logic [31:0]                idx_ext;
    logic                       idx_in_mem;
    logic                       idx_is_side;
    logic                       chain_ok;
    logic [1:0]                 piece;
    logic                       rd;
    logic [zph_pkg::ADDR_W-1:0] rd_addr;

    assign idx_ext     = {{(32 - zph_pkg::INDEX_W){1'b0}}, i_table_index};
    assign idx_in_mem  = idx_ext < 32'(zph_pkg::MEM_DEPTH);
    assign idx_is_side = idx_ext == 32'(zph_pkg::SIDE_INDEX);
    assign chain_ok    = !i_chain_origin_square[5]
                         && ({27'b0, i_chain_origin_square[4:0]} < 32'(zph_pkg::NUM_SQUARES));

    // white wins when both maps mark the square
    always_comb begin
        priority if (r_white[0]) begin
            piece = r_kings[0] ? zph_pkg::PIECE_WHITE_KING : zph_pkg::PIECE_WHITE_MAN;
        end else begin
            piece = r_kings[0] ? zph_pkg::PIECE_BLACK_KING : zph_pkg::PIECE_BLACK_MAN;
        end
    end

    assign rd      = i_cmd.rd_piece || i_cmd.rd_chain;
    assign rd_addr = i_cmd.rd_chain
                     ? zph_pkg::ADDR_W'(zph_pkg::PIECE_DEPTH) + zph_pkg::ADDR_W'(r_origin)
                     : zph_pkg::ADDR_W'({i_cmd.step, piece});

    always_comb begin
        n_rd_en = 1'b0;
        if (i_cmd.rd_piece) begin
            n_rd_en = r_white[0] || r_black[0];
        end else if (i_cmd.rd_chain) begin
            n_rd_en = r_chain_ok;
        end
        n_acc = r_acc;
        if (i_cmd.start) begin
            n_acc = i_white_to_move ? r_side_word : '0;
        end else if (r_rd_en) begin
            n_acc = r_acc ^ r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && idx_in_mem) begin
            mem[zph_pkg::ADDR_W'(i_table_index)] <= i_table_word;
        end else if (rd) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_en <= 1'b0;
        end else begin
            r_rd_en <= n_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && idx_is_side) begin
            r_side_word <= i_table_word;
        end
        if (i_cmd.start) begin
            r_white    <= i_white_pieces;
            r_black    <= i_black_pieces;
            r_kings    <= i_king_marks;
            r_origin   <= i_chain_origin_square[4:0];
            r_chain_ok <= chain_ok;
        end else if (i_cmd.rd_piece) begin
            r_white <= r_white >> 1;
            r_black <= r_black >> 1;
            r_kings <= r_kings >> 1;
        end
        r_acc <= n_acc;
        if (i_cmd.push) begin
            r_out <= r_acc;
        end
    end

    assign o_position_hash = r_out;

endmodule

@@ rtl/zobrist_position_hash.sv @@
// Load words: one per cycle while the block is idle, no result.
// Hash words: one table read per square plus the chain-origin read from the
// single-port table memory; the result is pushed once the output slot is free,
// and the next word is accepted only after that push.
// Reset (synchronous, active low) clears control and output valid; tables undefined
// until loaded.
module zobrist_position_hash (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_kind,
    input  logic [zph_pkg::INDEX_W-1:0]   i_table_index,
    input  logic [zph_pkg::WORD_W-1:0]    i_table_word,
    input  logic [zph_pkg::MAP_W-1:0]     i_white_pieces,
    input  logic [zph_pkg::MAP_W-1:0]     i_black_pieces,
    input  logic [zph_pkg::MAP_W-1:0]     i_king_marks,
    input  logic                          i_white_to_move,
    input  logic [zph_pkg::ORIGIN_W-1:0]  i_chain_origin_square,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [zph_pkg::WORD_W-1:0]    o_position_hash
);

    zph_pkg::t_cmd cmd;

    zph_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    zph_datapath u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_table_index         (i_table_index),
        .i_table_word          (i_table_word),
        .i_white_pieces        (i_white_pieces),
        .i_black_pieces        (i_black_pieces),
        .i_king_marks          (i_king_marks),
        .i_white_to_move       (i_white_to_move),
        .i_chain_origin_square (i_chain_origin_square),
        .o_position_hash       (o_position_hash)
    );

endmodule

@@ rtl/zph_checker.sv @@
module zph_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       i_kind,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [zph_pkg::WORD_W-1:0] o_position_hash
);

    // held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_position_hash))
        else $error("stalled result word changed");

    // a hash word occupies the block
    a_hash_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_kind == zph_pkg::KIND_HASH) |=> o_stall)
        else $error("hash word did not start a run");

    // a load word never blocks the next one
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_kind == zph_pkg::KIND_LOAD) |=> !o_stall)
        else $error("load word stalled input");

    // a result only follows a run
    a_out_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result word without a run");

endmodule

bind zobrist_position_hash zph_checker u_zph_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_kind          (i_kind),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_position_hash (o_position_hash)
);
